// ===== hdl/mte_pkg.sv =====
// Package for the Morse text encoder: element codes, pattern ROM, counter widths
// and the command/status structs between controller and datapath.
// No dependencies.
package mte_pkg;

   localparam int SKIP_COUNT_BITS = 16;
   localparam int SHOW_W          = 16;
   localparam int CNT_EXT_W       = (SKIP_COUNT_BITS > SHOW_W) ? SKIP_COUNT_BITS : SHOW_W;

   typedef logic [2:0] element_type;

   localparam element_type EL_DIT    = 3'd0;
   localparam element_type EL_DAH    = 3'd1;
   localparam element_type EL_INTRA  = 3'd2;
   localparam element_type EL_LETTER = 3'd3;
   localparam element_type EL_WORD   = 3'd4;
   localparam element_type EL_SKIP   = 3'd5;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_LAST    = 8'd95;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   // Marker 1 then symbols, first symbol most significant, dah = 1. Zero: no code.
   localparam logic [7:0] PATTERN_ROM [64] = '{
      8'h00, 8'h6B, 8'h52, 8'h00, 8'h89, 8'h00, 8'h28, 8'h5E,
      8'h36, 8'h6D, 8'h00, 8'h2A, 8'h73, 8'h61, 8'h55, 8'h32,
      8'h3F, 8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38,
      8'h3C, 8'h3E, 8'h78, 8'h6A, 8'h00, 8'h31, 8'h00, 8'h4C,
      8'h5A, 8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E,
      8'h10, 8'h04, 8'h17, 8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F,
      8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03, 8'h09, 8'h11, 8'h0B,
      8'h19, 8'h1B, 8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4D
   };

   // Position of the marker bit, which equals the number of symbols.
   function automatic logic [2:0] pattern_length(input logic [7:0] pat);
      logic [2:0] len;
      len = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (pat[i]) begin
            len = 3'(i);
         end
      end
      return len;
   endfunction

   typedef struct packed {
      logic load;
      logic step;
   } mte_cmd_type;

   typedef struct packed {
      logic next_last;
   } mte_status_type;

endpackage

// ===== hdl/mte_if.sv =====
// Valid/ready channel interfaces for the Morse text encoder.
// Depends on mte_pkg.
interface mte_req_if import mte_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       first_of_text;

   modport source (output valid, output character, output first_of_text, input ready);
   modport sink   (input valid, input character, input first_of_text, output ready);
endinterface

interface mte_rsp_if import mte_pkg::*; ();
   logic                valid;
   logic                ready;
   element_type         element;
   logic                last;
   logic [SHOW_W-1:0]   skipped_count;

   modport source (output valid, output element, output last, output skipped_count,
                   input ready);
   modport sink   (input valid, input element, input last, input skipped_count,
                   output ready);
endinterface

// ===== hdl/mte_datapath.sv =====
// Datapath of the Morse text encoder: ROM lookup, symbol shift register,
// word and skip state, result register. Depends on mte_pkg.
module mte_datapath import mte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  mte_cmd_type         cmd,
   output mte_status_type      status,
   input  logic [7:0]          character,
   input  logic                first_of_text,
   output element_type         out_element,
   output logic                out_last,
   output logic [SHOW_W-1:0]   out_skipped_count
);

   logic                       word_start_ff, word_start_in;
   logic [SKIP_COUNT_BITS-1:0] skip_cnt_ff, skip_cnt_in;
   logic                       single_ff, single_in;
   element_type                single_el_ff, single_el_in;
   logic                       lead_ff, lead_in;
   logic                       gap_ff, gap_in;
   logic [6:0]                 sym_ff, sym_in;
   logic [2:0]                 nsym_ff, nsym_in;
   element_type                el_ff, el_in;
   logic                       last_ff, last_in;
   logic [SHOW_W-1:0]          shown_ff, shown_in;

   logic [7:0]                 ch_up;
   logic                       in_range;
   logic [5:0]                 rom_idx;
   logic [7:0]                 pat;
   logic [2:0]                 plen;
   logic [7:0]                 aligned;
   logic                       is_space, is_skip, ws_eff;
   logic [SKIP_COUNT_BITS-1:0] cnt_base;
   logic [CNT_EXT_W-1:0]       cnt_ext;
   element_type                next_el;
   logic                       next_last;

   // Decode of the incoming byte
   always_comb begin
      ch_up    = (character >= CHAR_LOWER_A && character <= CHAR_LOWER_Z) ?
                 character - CASE_OFFSET : character;
      in_range = (ch_up >= CHAR_SPACE) && (ch_up <= CHAR_LAST);
      rom_idx  = 6'(ch_up - CHAR_SPACE);
      pat      = in_range ? PATTERN_ROM[rom_idx] : 8'h00;
      plen     = pattern_length(pat);
      aligned  = pat << (3'd7 - plen);
      is_space = (character == CHAR_SPACE);
      is_skip  = !is_space && (pat == 8'h00);
      ws_eff   = first_of_text || word_start_ff;
      cnt_base = first_of_text ? '0 : skip_cnt_ff;
   end

   // Element selection from the sequence state
   always_comb begin
      if (single_ff) begin
         next_el   = single_el_ff;
         next_last = 1'b1;
      end else if (lead_ff) begin
         next_el   = EL_LETTER;
         next_last = 1'b0;
      end else if (gap_ff) begin
         next_el   = EL_INTRA;
         next_last = 1'b0;
      end else begin
         next_el   = sym_ff[6] ? EL_DAH : EL_DIT;
         next_last = (nsym_ff == 3'd1);
      end
   end

   assign status.next_last = next_last;
   assign cnt_ext = CNT_EXT_W'(skip_cnt_ff);

   always_comb begin
      word_start_in = word_start_ff;
      skip_cnt_in   = skip_cnt_ff;
      single_in     = single_ff;
      single_el_in  = single_el_ff;
      lead_in       = lead_ff;
      gap_in        = gap_ff;
      sym_in        = sym_ff;
      nsym_in       = nsym_ff;
      el_in         = el_ff;
      last_in       = last_ff;
      shown_in      = shown_ff;
      if (cmd.load) begin
         single_in    = is_space || is_skip;
         single_el_in = is_space ? EL_WORD : EL_SKIP;
         lead_in      = !(is_space || is_skip) && !ws_eff;
         gap_in       = 1'b0;
         sym_in       = aligned[6:0];
         nsym_in      = plen;
         if (is_space) begin
            word_start_in = 1'b1;
         end else if (is_skip) begin
            word_start_in = ws_eff;
         end else begin
            word_start_in = 1'b0;
         end
         // saturate at all ones
         if (is_skip && (cnt_base != '1)) begin
            skip_cnt_in = SKIP_COUNT_BITS'(cnt_base + 1'b1);
         end else begin
            skip_cnt_in = cnt_base;
         end
      end else if (cmd.step) begin
         el_in    = next_el;
         last_in  = next_last;
         shown_in = (cnt_ext > CNT_EXT_W'({SHOW_W{1'b1}})) ?
                    {SHOW_W{1'b1}} : cnt_ext[SHOW_W-1:0];
         if (single_ff) begin
            single_in = 1'b0;
         end else if (lead_ff) begin
            lead_in = 1'b0;
         end else if (gap_ff) begin
            gap_in = 1'b0;
         end else begin
            sym_in  = {sym_ff[5:0], 1'b0};
            nsym_in = nsym_ff - 3'd1;
            gap_in  = (nsym_ff != 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_start_ff <= 1'b1;
         skip_cnt_ff   <= '0;
         single_ff     <= 1'b0;
         lead_ff       <= 1'b0;
         gap_ff        <= 1'b0;
         nsym_ff       <= 3'd0;
      end else begin
         word_start_ff <= word_start_in;
         skip_cnt_ff   <= skip_cnt_in;
         single_ff     <= single_in;
         lead_ff       <= lead_in;
         gap_ff        <= gap_in;
         nsym_ff       <= nsym_in;
      end
   end

   always_ff @(posedge clock) begin
      single_el_ff <= single_el_in;
      sym_ff       <= sym_in;
      el_ff        <= el_in;
      last_ff      <= last_in;
      shown_ff     <= shown_in;
   end

   assign out_element       = el_ff;
   assign out_last          = last_ff;
   assign out_skipped_count = shown_ff;

endmodule

// ===== hdl/mte_ctrl.sv =====
// Controller of the Morse text encoder: accepts a byte, then steps the
// datapath once per free result slot. Depends on mte_pkg.
module mte_ctrl import mte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output mte_cmd_type    cmd,
   input  mte_status_type status
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EMIT = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.step     = 1'b1;
               out_valid_in = 1'b1;
               // drop back once the final element of the byte is pushed
               if (status.next_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE)
      else $error("load outside idle");

   a_step_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> slot_free)
      else $error("step into occupied result register");

   a_load_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_EMIT)
      else $error("no emission after load");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.next_last |=> state_ff == S_IDLE && out_valid_ff)
      else $error("final element not presented");

endmodule

// ===== hdl/morse_text_encoder.sv =====
// Top level of the Morse text encoder: joins controller and datapath to the
// request and response channels. Depends on mte_pkg, mte_if, mte_ctrl, mte_datapath.
//
//   channel  dir  payload                              handshake
//   req_ch   in   character, first_of_text             valid/ready
//   rsp_ch   out  element, last, skipped_count         valid/ready
//
// A byte is taken and yields 1 to 14 elements, one per cycle when the sink
// never stalls.
// The next byte is accepted once the final element sits in the result register.
// A response stall holds the result register and pauses the element sequencer.
// Synchronous active-high reset; after reset a word starts and the count is zero.
module morse_text_encoder import mte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mte_req_if.sink   req_ch,
   mte_rsp_if.source rsp_ch
);

   mte_cmd_type    cmd;
   mte_status_type status;

   mte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   mte_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .character         (req_ch.character),
      .first_of_text     (req_ch.first_of_text),
      .out_element       (rsp_ch.element),
      .out_last          (rsp_ch.last),
      .out_skipped_count (rsp_ch.skipped_count)
   );

endmodule
